FILE: hdl/imuco_pkg.sv
// Shared types, constants and helper functions of the IMU complementary
// orientation block. Depends on nothing; every other file uses it.
package imuco_pkg;

  // Fixed point format of angles and the CORDIC length
  localparam int FRAC_BITS = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_RUN = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  // Datapath widths
  localparam int CFG_W = 17;
  localparam int SQRT_W = 48;
  localparam int SQRT_STEPS = SQRT_W / 2;
  localparam int CORD_W = 44;
  localparam int CAL_W = 48;
  localparam int DIV_W = (32 + FRAC_BITS > CAL_W) ? 32 + FRAC_BITS : CAL_W;
  localparam int DEN_W = 26;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Numeric constants
  localparam logic [DEN_W-1:0] GYRO_SCALE = DEN_W'(1000);
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic signed [31:0] NINETY = 32'(64'd90 << FRAC_BITS);
  localparam logic [CORD_W-1:0] NORM_LIMIT = CORD_W'(1) << 38;
  localparam logic [CORD_W-1:0] NORM_LIMIT_BYTE = NORM_LIMIT >> 8;

  // Register reset values
  localparam logic [15:0] RST_GYRO_SENS = 16'd131;
  localparam logic [16:0] RST_YAW_WEIGHT = 17'd62915;
  localparam logic [16:0] RST_TILT_WEIGHT = 17'd2621;
  localparam logic [15:0] RST_CALIB_SAMPLES = 16'd500;

  typedef enum logic [1:0] {
    REG_GYRO_SENS,
    REG_YAW_WEIGHT,
    REG_TILT_WEIGHT,
    REG_CALIB_SAMPLES
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [15:0]        elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] yaw_deg;
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic               calibrating;
  } result_t;

  typedef struct packed {
    logic [15:0] gyro_sensitivity;
    logic [16:0] yaw_gyro_weight;
    logic [16:0] tilt_gyro_weight;
    logic [15:0] calib_samples;
  } cfg_t;

  // Classified sample handed from the front end to the engine
  typedef struct packed {
    logic [16:0]        mag_x;
    logic [16:0]        mag_y;
    logic [16:0]        mag_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic [31:0]        sq_yz;
    logic [31:0]        sq_xz;
    logic [31:0]        sq_xy;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [15:0]        elapsed_ms;
  } work_t;

  typedef logic [ATAN_ENTRIES-1:0][31:0] atan_tab_t;

  function automatic logic [16:0] mag16(logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // atan(2^-i) in units of 1e-9 degree
  function automatic longint unsigned atan_nanodeg(int i);
    case (i)
      0: return 64'd45000000000;
      1: return 64'd26565051177;
      2: return 64'd14036243468;
      3: return 64'd7125016349;
      4: return 64'd3576334375;
      5: return 64'd1789910608;
      6: return 64'd895173710;
      7: return 64'd447614171;
      8: return 64'd223810500;
      9: return 64'd111905677;
      10: return 64'd55952892;
      11: return 64'd27976453;
      12: return 64'd13988227;
      13: return 64'd6994114;
      14: return 64'd3497057;
      15: return 64'd1748528;
      16: return 64'd874264;
      17: return 64'd437132;
      18: return 64'd218566;
      19: return 64'd109283;
      20: return 64'd54642;
      21: return 64'd27321;
      22: return 64'd13660;
      23: return 64'd6830;
      default: return 64'd0;
    endcase
  endfunction

  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    longint unsigned nd;
    for (int i = 0; i < ATAN_ENTRIES; i++) begin
      nd = atan_nanodeg(i);
      t[i] = 32'(((nd << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_Q = atan_table();

endpackage

FILE: hdl/imuco_sample_if.sv
// Input channel of the IMU orientation block: valid/ready and one raw sample.
// Depends on imuco_pkg for the sample type.
interface imuco_sample_if;
  logic               valid;
  logic               ready;
  imuco_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/imuco_result_if.sv
// Output channel of the IMU orientation block: valid/ready and one result.
// Depends on imuco_pkg for the result type.
interface imuco_result_if;
  logic               valid;
  logic               ready;
  imuco_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/imu_complementary_orientation_top.sv
// Top level of the IMU complementary orientation block: configuration
// registers, front end, queue and engine. Depends on imuco_pkg and both
// channel interfaces.
//
// Usage: raw six-axis samples with elapsed milliseconds enter on "sample";
// one result (yaw, roll, pitch in Q15.16 degrees minus offsets, plus the
// calibrating flag) leaves on "result" per sample. A transfer happens on a
// clock edge with valid and ready both high.
// The engine runs three 24-step square roots, three CORDIC runs of 16 steps
// plus a short normalization, three 48-step gyro divisions and three blends
// (gyro product, tilt product, sum) on one shared sequencer; the bit-serial
// divider takes the largest share of the time.
// Throughput is one sample per engine pass. The sample ending calibration
// adds three more 48-step divisions for the offsets.
// The front end squares the next sample and a two-entry queue holds it while
// the engine is busy, so input keeps flowing while a result waits.
// Reset (rst, synchronous) restores register defaults, clears gyro angles,
// offsets, sums and the sample count. When the receiver stalls, the result
// is held in the output register and the engine waits before its next write.
module imu_complementary_orientation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  imuco_sample_if.sink   sample,
  imuco_result_if.source result
);

  imuco_pkg::cfg_t  cfg;
  logic             push_valid;
  logic             push_ready;
  imuco_pkg::work_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  imuco_pkg::work_t pop_data;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_sensitivity <= imuco_pkg::RST_GYRO_SENS;
      cfg.yaw_gyro_weight <= imuco_pkg::RST_YAW_WEIGHT;
      cfg.tilt_gyro_weight <= imuco_pkg::RST_TILT_WEIGHT;
      cfg.calib_samples <= imuco_pkg::RST_CALIB_SAMPLES;
    end else if (cfg_we) begin
      unique case (imuco_pkg::cfg_reg_t'(cfg_index))
        imuco_pkg::REG_GYRO_SENS: cfg.gyro_sensitivity <= cfg_data[15:0];
        imuco_pkg::REG_YAW_WEIGHT: cfg.yaw_gyro_weight <= cfg_data;
        imuco_pkg::REG_TILT_WEIGHT: cfg.tilt_gyro_weight <= cfg_data;
        imuco_pkg::REG_CALIB_SAMPLES: cfg.calib_samples <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  imuco_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  imuco_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  imuco_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

FILE: hdl/imuco_front.sv
// Front end: takes one raw sample, splits signs and magnitudes and forms the
// three sums of squares with one shared multiplier. Depends on imuco_pkg.
module imuco_front (
  input  logic             clk,
  input  logic             rst,
  imuco_sample_if.sink     sample,
  output logic             push_valid,
  input  logic             push_ready,
  output imuco_pkg::work_t push_data
);

  typedef enum logic [1:0] {F_IDLE, F_SQUARE, F_PUSH} front_state_t;

  front_state_t       state;
  imuco_pkg::sample_t hold;
  logic [1:0]         step;
  logic [30:0]        sq_x;
  logic [30:0]        sq_y;
  logic [30:0]        sq_z;
  logic [16:0]        mag_sel;
  logic [33:0]        sq_full;

  assign sample.ready = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);

  // Select the axis to square this cycle
  always_comb begin
    case (step)
      2'd0: mag_sel = imuco_pkg::mag16(hold.accel_x);
      2'd1: mag_sel = imuco_pkg::mag16(hold.accel_y);
      default: mag_sel = imuco_pkg::mag16(hold.accel_z);
    endcase
    sq_full = 34'(mag_sel) * 34'(mag_sel);
  end

  // Assemble the classified record
  always_comb begin
    push_data.mag_x = imuco_pkg::mag16(hold.accel_x);
    push_data.mag_y = imuco_pkg::mag16(hold.accel_y);
    push_data.mag_z = imuco_pkg::mag16(hold.accel_z);
    push_data.neg_x = hold.accel_x[15];
    push_data.neg_y = hold.accel_y[15];
    push_data.neg_z = hold.accel_z[15];
    push_data.sq_yz = 32'(sq_y) + 32'(sq_z);
    push_data.sq_xz = 32'(sq_x) + 32'(sq_z);
    push_data.sq_xy = 32'(sq_x) + 32'(sq_y);
    push_data.rate_x = hold.rate_x;
    push_data.rate_y = hold.rate_y;
    push_data.rate_z = hold.rate_z;
    push_data.elapsed_ms = hold.elapsed_ms;
  end

  // Capture, square three axes, then hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step <= 2'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (sample.valid) begin
            hold <= sample.data;
            step <= 2'd0;
            state <= F_SQUARE;
          end
        end
        F_SQUARE: begin
          case (step)
            2'd0: sq_x <= sq_full[30:0];
            2'd1: sq_y <= sq_full[30:0];
            default: sq_z <= sq_full[30:0];
          endcase
          if (step == 2'd2) begin
            state <= F_PUSH;
          end else begin
            step <= step + 2'd1;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/imuco_queue.sv
// Short queue of classified samples between front end and engine.
// Depends on imuco_pkg for the record type and depth.
module imuco_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  imuco_pkg::work_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output imuco_pkg::work_t pop_data
);

  localparam int PW = imuco_pkg::QUEUE_PTR_W;
  localparam int CW = imuco_pkg::QUEUE_CNT_W;

  imuco_pkg::work_t entries [imuco_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(imuco_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = entries[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(imuco_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(imuco_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(imuco_pkg::QUEUE_DEPTH))
    else $error("queue fill level beyond depth");
`endif

endmodule

FILE: hdl/imuco_back.sv
// Engine: square roots, CORDIC tilt angles, gyro integration, blending and
// offset calibration on shared bit-serial units. Depends on imuco_pkg and
// the result interface.
module imuco_back (
  input  logic             clk,
  input  logic             rst,
  input  imuco_pkg::cfg_t  cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  imuco_pkg::work_t pop_data,
  imuco_result_if.source   result
);

  localparam int SW = imuco_pkg::SQRT_W;
  localparam int CW = imuco_pkg::CORD_W;
  localparam int DW = imuco_pkg::DIV_W;
  localparam int NW = imuco_pkg::DEN_W;
  localparam int AW = imuco_pkg::CAL_W;
  localparam int FB = imuco_pkg::FRAC_BITS;

  typedef enum logic [4:0] {
    B_IDLE, B_SQRT_INIT, B_SQRT, B_ATAN_INIT, B_NORM, B_CORDIC, B_TILT,
    B_GYRO_MUL, B_GYRO_DIV_INIT, B_GYRO_DIV, B_GYRO_ADD,
    B_BLEND_G, B_BLEND_A, B_BLEND_SUM, B_OUT,
    B_CAL_DIV_INIT, B_CAL_DIV, B_CAL_END
  } back_state_t;

  back_state_t        state;
  imuco_pkg::work_t   item;
  logic [1:0]         axis;
  logic [5:0]         cnt;
  logic [SW-1:0]      sq_v;
  logic [SW-1:0]      sq_r;
  logic [SW-1:0]      sq_b;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [31:0] cz;
  logic signed [31:0] tilt [3];
  logic signed [31:0] integ [3];
  logic signed [31:0] ang [3];
  logic signed [31:0] offset [3];
  logic signed [AW-1:0] cal_sum [3];
  logic [15:0]        sample_count;
  logic               calibration_done;
  logic signed [49:0] prod;
  logic signed [49:0] acc;
  logic [DW-1:0]      div_num;
  logic [NW:0]        div_rem;
  logic [NW-1:0]      div_den;
  logic               div_neg;
  logic               out_valid;
  imuco_pkg::result_t out_data;

  // Combinational helpers
  logic [15:0]        sens;
  logic [15:0]        limit;
  logic [NW-1:0]      den_c;
  logic [16:0]        w_yaw;
  logic [16:0]        w_tilt;
  logic [16:0]        w_sel;
  logic [16:0]        w_comp;
  logic [1:0]         src;
  logic [1:0]         integ_idx;
  logic signed [31:0] integ_rd;
  logic signed [15:0] rate_sel;
  logic [16:0]        rate_mag;
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic [31:0]        sq_sum;
  logic [SW-1:0]      sq_t;
  logic               sq_ge;
  logic [24:0]        atan_n;
  logic [24:0]        atan_d;
  logic               tilt_neg;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [31:0] tab;
  logic signed [31:0] zc;
  logic [NW:0]        rem_sh;
  logic               div_ge;
  logic signed [63:0] q_s;
  logic signed [63:0] blend_s;
  logic [AW-1:0]      cal_mag;
  logic [15:0]        count_n;
  logic               out_free;

  assign pop_ready = (state == B_IDLE);
  assign result.valid = out_valid;
  assign result.data = out_data;
  assign out_free = !out_valid || result.ready;

  // Register-derived operands
  always_comb begin
    sens = (cfg.gyro_sensitivity == 16'd0) ? 16'd1 : cfg.gyro_sensitivity;
    limit = (cfg.calib_samples == 16'd0) ? 16'd1 : cfg.calib_samples;
    den_c = NW'(sens) * imuco_pkg::GYRO_SCALE;
    w_yaw = (cfg.yaw_gyro_weight > imuco_pkg::WEIGHT_ONE) ? imuco_pkg::WEIGHT_ONE
                                                          : cfg.yaw_gyro_weight;
    w_tilt = (cfg.tilt_gyro_weight > imuco_pkg::WEIGHT_ONE) ? imuco_pkg::WEIGHT_ONE
                                                            : cfg.tilt_gyro_weight;
    w_sel = (axis == 2'd0) ? w_yaw : w_tilt;
    w_comp = 17'(18'(imuco_pkg::WEIGHT_ONE) - 18'(w_sel));
    // yaw blends gyro z, roll gyro x, pitch gyro y
    src = (axis == 2'd0) ? 2'd2 : axis - 2'd1;
    integ_idx = (state == B_BLEND_G) ? src : axis;
    integ_rd = integ[integ_idx];
  end

  // Per-axis selections
  always_comb begin
    case (axis)
      2'd0: begin
        rate_sel = item.rate_x;
        sq_sum = item.sq_yz;
        tilt_neg = item.neg_x;
        atan_n = {item.mag_x, 8'd0};
        atan_d = sq_r[24:0];
      end
      2'd1: begin
        rate_sel = item.rate_y;
        sq_sum = item.sq_xz;
        tilt_neg = item.neg_y;
        atan_n = {item.mag_y, 8'd0};
        atan_d = sq_r[24:0];
      end
      default: begin
        rate_sel = item.rate_z;
        sq_sum = item.sq_xy;
        tilt_neg = item.neg_z;
        atan_n = sq_r[24:0];
        atan_d = {item.mag_z, 8'd0};
      end
    endcase
    rate_mag = imuco_pkg::mag16(rate_sel);
  end

  // Shared multiplier operands
  always_comb begin
    case (state)
      B_GYRO_MUL: begin
        mul_a = $signed({15'd0, rate_mag});
        mul_b = $signed({2'd0, item.elapsed_ms});
      end
      B_BLEND_G: begin
        mul_a = integ_rd;
        mul_b = $signed({1'b0, w_sel});
      end
      default: begin
        mul_a = tilt[src];
        mul_b = $signed({1'b0, w_comp});
      end
    endcase
  end

  // One step of each serial unit
  always_comb begin
    sq_t = sq_r + sq_b;
    sq_ge = (sq_v >= sq_t);
    xs = cx >>> cnt[4:0];
    ys = cy >>> cnt[4:0];
    tab = $signed(imuco_pkg::ATAN_Q[cnt[4:0]]);
    if (cz < 32'sd0) begin
      zc = 32'sd0;
    end else if (cz > imuco_pkg::NINETY) begin
      zc = imuco_pkg::NINETY;
    end else begin
      zc = cz;
    end
    rem_sh = {div_rem[NW-1:0], div_num[DW-1]};
    div_ge = (rem_sh >= {1'b0, div_den});
    q_s = $signed(64'(div_num));
    blend_s = (64'(acc) + 64'(prod) + 64'sd32768) >>> 16;
    cal_mag = cal_sum[axis][AW-1] ? AW'(-cal_sum[axis]) : AW'(cal_sum[axis]);
    count_n = (sample_count != 16'hffff) ? sample_count + 16'd1 : sample_count;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      axis <= 2'd0;
      cnt <= '0;
      out_valid <= 1'b0;
      sample_count <= '0;
      calibration_done <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        integ[i] <= '0;
        offset[i] <= '0;
        cal_sum[i] <= '0;
      end
    end else begin
      // raise the result when the engine finishes, drop it once transferred
      if (state == B_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            item <= pop_data;
            axis <= 2'd0;
            state <= B_SQRT_INIT;
          end
        end
        B_SQRT_INIT: begin
          sq_v <= {sq_sum, 16'd0};
          sq_r <= '0;
          sq_b <= SW'(1) << (SW - 2);
          cnt <= '0;
          state <= B_SQRT;
        end
        B_SQRT: begin
          if (sq_ge) begin
            sq_v <= sq_v - sq_t;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(imuco_pkg::SQRT_STEPS - 1)) begin
            state <= B_ATAN_INIT;
          end
        end
        B_ATAN_INIT: begin
          cx <= CW'(atan_d);
          cy <= CW'(atan_n);
          if (atan_n == '0) begin
            cz <= 32'sd0;
            state <= B_TILT;
          end else if (atan_d == '0) begin
            cz <= imuco_pkg::NINETY;
            state <= B_TILT;
          end else begin
            state <= B_NORM;
          end
        end
        B_NORM: begin
          if ($unsigned(cx) < imuco_pkg::NORM_LIMIT && $unsigned(cy) < imuco_pkg::NORM_LIMIT) begin
            if ($unsigned(cx) < imuco_pkg::NORM_LIMIT_BYTE &&
                $unsigned(cy) < imuco_pkg::NORM_LIMIT_BYTE) begin
              cx <= cx <<< 8;
              cy <= cy <<< 8;
            end else begin
              cx <= cx <<< 1;
              cy <= cy <<< 1;
            end
          end else begin
            cnt <= '0;
            cz <= 32'sd0;
            state <= B_CORDIC;
          end
        end
        B_CORDIC: begin
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + tab;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - tab;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(imuco_pkg::CORDIC_RUN - 1)) begin
            state <= B_TILT;
          end
        end
        B_TILT: begin
          tilt[axis] <= tilt_neg ? -zc : zc;
          if (axis == 2'd2) begin
            axis <= 2'd0;
            state <= B_GYRO_MUL;
          end else begin
            axis <= axis + 2'd1;
            state <= B_SQRT_INIT;
          end
        end
        B_GYRO_MUL: begin
          prod <= mul_a * mul_b;
          state <= B_GYRO_DIV_INIT;
        end
        B_GYRO_DIV_INIT: begin
          div_num <= DW'({prod[30:0], {FB{1'b0}}}) + DW'(den_c[NW-1:1]);
          div_den <= den_c;
          div_rem <= '0;
          div_neg <= rate_sel[15];
          cnt <= '0;
          state <= B_GYRO_DIV;
        end
        B_GYRO_DIV: begin
          div_rem <= div_ge ? rem_sh - {1'b0, div_den} : rem_sh;
          div_num <= {div_num[DW-2:0], div_ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DW - 1)) begin
            state <= B_GYRO_ADD;
          end
        end
        B_GYRO_ADD: begin
          integ[axis] <= imuco_pkg::sat32(64'(integ_rd) + (div_neg ? -q_s : q_s));
          if (axis == 2'd2) begin
            axis <= 2'd0;
            state <= B_BLEND_G;
          end else begin
            axis <= axis + 2'd1;
            state <= B_GYRO_MUL;
          end
        end
        B_BLEND_G: begin
          prod <= mul_a * mul_b;
          state <= B_BLEND_A;
        end
        B_BLEND_A: begin
          acc <= prod;
          prod <= mul_a * mul_b;
          state <= B_BLEND_SUM;
        end
        B_BLEND_SUM: begin
          ang[axis] <= imuco_pkg::sat32(blend_s);
          if (axis == 2'd2) begin
            axis <= 2'd0;
            state <= B_OUT;
          end else begin
            axis <= axis + 2'd1;
            state <= B_BLEND_G;
          end
        end
        B_OUT: begin
          // hold until the output register frees
          if (out_free) begin
            out_data.yaw_deg <= imuco_pkg::sat32(64'(ang[0]) - 64'(offset[0]));
            out_data.roll_deg <= imuco_pkg::sat32(64'(ang[1]) - 64'(offset[1]));
            out_data.pitch_deg <= imuco_pkg::sat32(64'(ang[2]) - 64'(offset[2]));
            out_data.calibrating <= !calibration_done;
            state <= B_IDLE;
            if (!calibration_done) begin
              for (int i = 0; i < 3; i++) begin
                cal_sum[i] <= cal_sum[i] + AW'(ang[i]);
              end
              sample_count <= count_n;
              if (count_n >= limit) begin
                axis <= 2'd0;
                state <= B_CAL_DIV_INIT;
              end
            end
          end
        end
        B_CAL_DIV_INIT: begin
          div_num <= DW'(cal_mag) + DW'(sample_count[15:1]);
          div_den <= NW'(sample_count);
          div_rem <= '0;
          div_neg <= cal_sum[axis][AW-1];
          cnt <= '0;
          state <= B_CAL_DIV;
        end
        B_CAL_DIV: begin
          div_rem <= div_ge ? rem_sh - {1'b0, div_den} : rem_sh;
          div_num <= {div_num[DW-2:0], div_ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DW - 1)) begin
            state <= B_CAL_END;
          end
        end
        B_CAL_END: begin
          offset[axis] <= imuco_pkg::sat32(div_neg ? -q_s : q_s);
          integ[axis] <= '0;
          if (axis == 2'd2) begin
            axis <= 2'd0;
            calibration_done <= 1'b1;
            state <= B_IDLE;
          end else begin
            axis <= axis + 2'd1;
            state <= B_CAL_DIV_INIT;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    calibration_done |=> calibration_done)
    else $error("calibration flag dropped");

  a_clear_at_done: assert property (@(posedge clk) disable iff (rst)
    $rose(calibration_done) |-> (integ[0] == 0 && integ[1] == 0 && integ[2] == 0))
    else $error("gyro angles not cleared at end of calibration");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && out_valid && !result.ready) |=> (state == B_OUT && out_valid))
    else $error("finished result lost while receiver stalls");
`endif

endmodule
